// File: rtl/mft_pkg.sv
// ----------------------------------------------------------------------------
// mft_pkg: shared definitions for the multiset frequency table
// Command codes, field widths, parameter defaults and the control bundle
// passed from the update unit to the sequencer.
// ----------------------------------------------------------------------------
package mft_pkg;

    localparam int VALUE_W         = 10;
    localparam int CMD_W           = 2;
    localparam int OUT_CNT_W       = 16;
    localparam int VALUE_SLOTS_DEF = 1024;
    localparam int COUNT_BITS_DEF  = 16;

    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    typedef struct packed {
        logic ok;
        logic wr_en;
        logic scan_up;
        logic scan_down;
    } upd_ctrl_t;

endpackage

// File: rtl/mft_req_if.sv
// ----------------------------------------------------------------------------
// mft_req_if: command channel
// Valid/ready channel carrying one command beat: cmd and value.
// ----------------------------------------------------------------------------
interface mft_req_if;
    logic                                valid;
    logic                                ready;
    logic [mft_pkg::CMD_W-1:0]           cmd;
    logic signed [mft_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

// File: rtl/mft_rsp_if.sv
// ----------------------------------------------------------------------------
// mft_rsp_if: result channel
// Valid/ready channel carrying one result beat per command.
// ----------------------------------------------------------------------------
interface mft_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                ok;
    logic [mft_pkg::OUT_CNT_W-1:0]       occurrences;
    logic [mft_pkg::OUT_CNT_W-1:0]       total;
    logic                                empty_res;
    logic signed [mft_pkg::VALUE_W-1:0]  least;
    logic signed [mft_pkg::VALUE_W-1:0]  greatest;

    modport source (output valid, output ok, output occurrences, output total,
                    output empty_res, output least, output greatest, input ready);
    modport sink   (input valid, input ok, input occurrences, input total,
                    input empty_res, input least, input greatest, output ready);
endinterface

// File: rtl/multiset_frequency_table_top.sv
// ----------------------------------------------------------------------------
// multiset_frequency_table_top: multiset of small signed values
// Occurrence counter per value slot in RAM, with total, least and greatest.
// ----------------------------------------------------------------------------
// A command beat (query, add one copy, remove one copy) reads the value's
// counter from the slot RAM in the accept cycle; in the next cycle the block
// updates it, writes it back and loads the result register. Removing the last
// copy of the least or greatest member walks the RAM one slot per cycle toward
// the next member. When the previous result is still waiting in the result
// register, the finished command holds in a wait state until that beat is
// taken. After reset the block sweeps the slot RAM to zero, one slot per cycle,
// with ready low. Commands are taken one at a time; ready is high only while
// the sequencer is idle, and a finished result may wait in its register while
// the next command is taken.
// ----------------------------------------------------------------------------
module multiset_frequency_table_top #(
    parameter int VALUE_SLOTS = mft_pkg::VALUE_SLOTS_DEF,
    parameter int COUNT_BITS  = mft_pkg::COUNT_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    mft_req_if.sink   req,
    mft_rsp_if.source rsp
);

    localparam int VW        = mft_pkg::VALUE_W;
    localparam int SLOT_BITS = $clog2(VALUE_SLOTS);
    localparam int SW        = ((SLOT_BITS > VW) ? SLOT_BITS : VW) + 2;
    localparam logic signed [SW-1:0] OFFSET_S = SW'(VALUE_SLOTS / 2);
    localparam logic signed [SW-1:0] LIMIT_S  = SW'(VALUE_SLOTS);
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(VALUE_SLOTS - 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    // control state
    logic [2:0]            state_reg, state_next;
    logic [SLOT_BITS-1:0]  clear_addr_reg, clear_addr_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic signed [VW-1:0]  least_reg, least_next;
    logic signed [VW-1:0]  greatest_reg, greatest_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic                  chk_valid_reg, chk_valid_next;

    // held command and scan bookkeeping
    logic [mft_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic signed [VW-1:0]      val_reg, val_next;
    logic [SLOT_BITS-1:0]      slot_reg, slot_next;
    logic                      slot_ok_reg, slot_ok_next;
    logic                      res_ok_reg, res_ok_next;
    logic [COUNT_BITS-1:0]     res_cnt_reg, res_cnt_next;
    logic [SLOT_BITS-1:0]      scan_addr_reg, scan_addr_next;
    logic [SLOT_BITS-1:0]      chk_addr_reg, chk_addr_next;
    logic                      scan_up_reg, scan_up_next;

    // result register payload
    logic                          ok_reg, ok_next;
    logic [mft_pkg::OUT_CNT_W-1:0] occ_reg, occ_next;
    logic [mft_pkg::OUT_CNT_W-1:0] tot_reg, tot_next;
    logic                          empty_reg, empty_next;
    logic signed [VW-1:0]          lo_reg, lo_next;
    logic signed [VW-1:0]          hi_reg, hi_next;

    logic signed [SW-1:0]  req_slot_full;
    logic [SLOT_BITS-1:0]  req_slot;
    logic                  req_slot_ok;
    logic signed [SW-1:0]  found_full;
    logic signed [VW-1:0]  found_value;
    logic                  out_free;

    logic                  ram_wr_en;
    logic [SLOT_BITS-1:0]  ram_wr_addr;
    logic [COUNT_BITS-1:0] ram_wr_data;
    logic [SLOT_BITS-1:0]  ram_rd_addr;
    logic [COUNT_BITS-1:0] ram_rd_data;

    mft_pkg::upd_ctrl_t    upd_ctrl;
    logic [COUNT_BITS-1:0] upd_cnt;
    logic [COUNT_BITS-1:0] upd_total;
    logic signed [VW-1:0]  upd_least;
    logic signed [VW-1:0]  upd_greatest;

    // value v lives in slot v + VALUE_SLOTS/2
    assign req_slot_full = SW'(req.value) + OFFSET_S;
    assign req_slot_ok   = !req_slot_full[SW-1] && (req_slot_full < LIMIT_S);
    assign req_slot      = req_slot_full[SLOT_BITS-1:0];

    // slot under check back to its value
    assign found_full  = $signed(SW'(chk_addr_reg)) - OFFSET_S;
    assign found_value = found_full[VW-1:0];

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);

    mft_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (VALUE_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    mft_update #(
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .cmd          (cmd_reg),
        .slot_ok      (slot_ok_reg),
        .value        (val_reg),
        .rd_count     (ram_rd_data),
        .total        (total_reg),
        .least        (least_reg),
        .greatest     (greatest_reg),
        .ctrl         (upd_ctrl),
        .count_new    (upd_cnt),
        .total_new    (upd_total),
        .least_new    (upd_least),
        .greatest_new (upd_greatest)
    );

    always_comb
    begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        total_next      = total_reg;
        least_next      = least_reg;
        greatest_next   = greatest_reg;
        chk_valid_next  = chk_valid_reg;
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        slot_next       = slot_reg;
        slot_ok_next    = slot_ok_reg;
        res_ok_next     = res_ok_reg;
        res_cnt_next    = res_cnt_reg;
        scan_addr_next  = scan_addr_reg;
        chk_addr_next   = chk_addr_reg;
        scan_up_next    = scan_up_reg;

        // drop the result once taken; a load below overrides
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        ok_next        = ok_reg;
        occ_next       = occ_reg;
        tot_next       = tot_reg;
        empty_next     = empty_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = slot_reg;
        ram_wr_data = upd_cnt;
        ram_rd_addr = (state_reg == ST_IDLE) ? req_slot : scan_addr_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clear_addr_reg;
                ram_wr_data = '0;
                if (clear_addr_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clear_addr_next = clear_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next     = req.cmd;
                    val_next     = req.value;
                    slot_next    = req_slot;
                    slot_ok_next = req_slot_ok;
                    state_next   = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                ram_wr_en     = upd_ctrl.wr_en;
                total_next    = upd_total;
                least_next    = upd_least;
                greatest_next = upd_greatest;
                res_ok_next   = upd_ctrl.ok;
                res_cnt_next  = upd_cnt;
                if (upd_ctrl.scan_up || upd_ctrl.scan_down)
                begin
                    scan_up_next   = upd_ctrl.scan_up;
                    scan_addr_next = upd_ctrl.scan_up ? slot_reg + 1'b1 : slot_reg - 1'b1;
                    chk_valid_next = 1'b0;
                    state_next     = ST_SCAN;
                end
                else if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    ok_next        = upd_ctrl.ok;
                    occ_next       = mft_pkg::OUT_CNT_W'(upd_cnt);
                    tot_next       = mft_pkg::OUT_CNT_W'(upd_total);
                    empty_next     = (upd_total == '0);
                    lo_next        = upd_least;
                    hi_next        = upd_greatest;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (chk_valid_reg && ram_rd_data != '0)
                begin
                    if (scan_up_reg)
                    begin
                        least_next = found_value;
                    end
                    else
                    begin
                        greatest_next = found_value;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    // advance one slot; data for this address returns next cycle
                    chk_addr_next  = scan_addr_reg;
                    chk_valid_next = 1'b1;
                    scan_addr_next = scan_up_reg ? scan_addr_reg + 1'b1
                                                 : scan_addr_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    ok_next        = res_ok_reg;
                    occ_next       = mft_pkg::OUT_CNT_W'(res_cnt_reg);
                    tot_next       = mft_pkg::OUT_CNT_W'(total_reg);
                    empty_next     = (total_reg == '0);
                    lo_next        = least_reg;
                    hi_next        = greatest_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
            total_reg      <= '0;
            least_reg      <= '0;
            greatest_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
            chk_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
            total_reg      <= total_next;
            least_reg      <= least_next;
            greatest_reg   <= greatest_next;
            rsp_valid_reg  <= rsp_valid_next;
            chk_valid_reg  <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        val_reg       <= val_next;
        slot_reg      <= slot_next;
        slot_ok_reg   <= slot_ok_next;
        res_ok_reg    <= res_ok_next;
        res_cnt_reg   <= res_cnt_next;
        scan_addr_reg <= scan_addr_next;
        chk_addr_reg  <= chk_addr_next;
        scan_up_reg   <= scan_up_next;
        ok_reg        <= ok_next;
        occ_reg       <= occ_next;
        tot_reg       <= tot_next;
        empty_reg     <= empty_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.ok          = ok_reg;
    assign rsp.occurrences = occ_reg;
    assign rsp.total       = tot_reg;
    assign rsp.empty_res   = empty_reg;
    assign rsp.least       = lo_reg;
    assign rsp.greatest    = hi_reg;

endmodule

// File: rtl/mft_ram.sv
// ----------------------------------------------------------------------------
// mft_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mft_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/mft_update.sv
// ----------------------------------------------------------------------------
// mft_update: counter update unit
// Apply one command to a slot count, the total and the bounds; flag a rescan.
// ----------------------------------------------------------------------------
module mft_update #(
    parameter int COUNT_BITS = mft_pkg::COUNT_BITS_DEF
) (
    input  logic [mft_pkg::CMD_W-1:0]          cmd,
    input  logic                               slot_ok,
    input  logic signed [mft_pkg::VALUE_W-1:0] value,
    input  logic [COUNT_BITS-1:0]              rd_count,
    input  logic [COUNT_BITS-1:0]              total,
    input  logic signed [mft_pkg::VALUE_W-1:0] least,
    input  logic signed [mft_pkg::VALUE_W-1:0] greatest,
    output mft_pkg::upd_ctrl_t                 ctrl,
    output logic [COUNT_BITS-1:0]              count_new,
    output logic [COUNT_BITS-1:0]              total_new,
    output logic signed [mft_pkg::VALUE_W-1:0] least_new,
    output logic signed [mft_pkg::VALUE_W-1:0] greatest_new
);

    logic [COUNT_BITS-1:0] cnt;
    logic                  full;

    // Out-of-range values have no slot and read as zero copies
    assign cnt  = slot_ok ? rd_count : '0;
    assign full = (total == {COUNT_BITS{1'b1}});

    always_comb
    begin
        ctrl         = '0;
        count_new    = cnt;
        total_new    = total;
        least_new    = least;
        greatest_new = greatest;
        unique case (cmd)
            mft_pkg::CMD_ADD:
            begin
                if (slot_ok && !full)
                begin
                    ctrl.ok    = 1'b1;
                    ctrl.wr_en = 1'b1;
                    count_new  = cnt + 1'b1;
                    total_new  = total + 1'b1;
                    if (total == '0)
                    begin
                        least_new    = value;
                        greatest_new = value;
                    end
                    else
                    begin
                        if (value < least)    least_new    = value;
                        if (value > greatest) greatest_new = value;
                    end
                end
            end
            mft_pkg::CMD_REMOVE:
            begin
                if (slot_ok && cnt != '0)
                begin
                    ctrl.ok    = 1'b1;
                    ctrl.wr_en = 1'b1;
                    count_new  = cnt - 1'b1;
                    total_new  = total - 1'b1;
                    if (total_new == '0)
                    begin
                        least_new    = '0;
                        greatest_new = '0;
                    end
                    else if (count_new == '0)
                    begin
                        // last copy of a bound gone: find the next member
                        ctrl.scan_up   = (value == least);
                        ctrl.scan_down = (value == greatest);
                    end
                end
            end
            default:
            begin
                ctrl.ok = (cnt != '0);
            end
        endcase
    end

endmodule

// File: rtl/mft_chk.sv
// ----------------------------------------------------------------------------
// mft_chk: port-level checker for the multiset frequency table
// Watches the command and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module mft_chk (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               req_valid,
    input logic                               req_ready,
    input logic                               rsp_valid,
    input logic                               rsp_ready,
    input logic                               rsp_empty,
    input logic signed [mft_pkg::VALUE_W-1:0] rsp_least,
    input logic signed [mft_pkg::VALUE_W-1:0] rsp_greatest
);

    // one command at a time: busy right after a command beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("ready high right after a command beat");

    // an empty set reports both bounds as zero
    a_empty_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_empty) |-> (rsp_least == '0 && rsp_greatest == '0))
        else $error("empty set with nonzero bounds");

    // bounds stay ordered while the set holds members
    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_empty) |-> (rsp_least <= rsp_greatest))
        else $error("least above greatest");

    // a result beat waits until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("result beat dropped before taken");

endmodule

bind multiset_frequency_table_top mft_chk u_mft_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_empty    (rsp.empty_res),
    .rsp_least    (rsp.least),
    .rsp_greatest (rsp.greatest)
);
